// ===== src/ppu_scroll_register_and_dot_timer_assert.svh =====
// Assertion macros for the picture-unit scroll register and dot timer.
`ifndef PPU_SCROLL_REGISTER_AND_DOT_TIMER_ASSERT_SVH
`define PPU_SCROLL_REGISTER_AND_DOT_TIMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PPUSDT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPUSDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ppusdt_pkg.sv =====
// Types and constants shared by the scroll register and dot timer modules.
`default_nettype none

package ppusdt_pkg;

   // Request codes.
   typedef logic [1:0] req_code_type;
   localparam req_code_type REQ_WRITE = 2'd0;
   localparam req_code_type REQ_READ  = 2'd1;
   localparam req_code_type REQ_TICK  = 2'd2;

   // Data-port access codes.
   typedef logic [1:0] vram_code_type;
   localparam vram_code_type VRAM_NONE  = 2'd0;
   localparam vram_code_type VRAM_READ  = 2'd1;
   localparam vram_code_type VRAM_WRITE = 2'd2;

   // Register indexes.
   typedef logic [2:0] reg_code_type;
   localparam reg_code_type REG_CTRL     = 3'd0;
   localparam reg_code_type REG_MASK     = 3'd1;
   localparam reg_code_type REG_STATUS   = 3'd2;
   localparam reg_code_type REG_OAM_ADDR = 3'd3;
   localparam reg_code_type REG_OAM_DATA = 3'd4;
   localparam reg_code_type REG_SCROLL   = 3'd5;
   localparam reg_code_type REG_ADDR     = 3'd6;
   localparam reg_code_type REG_DATA     = 3'd7;

   // Raster geometry.
   localparam logic [9:0] DOTS_PER_LINE   = 10'd341;
   localparam logic [9:0] LINES_PER_FRAME = 10'd262;
   localparam logic [8:0] VISIBLE_LINES   = 9'd240;
   localparam logic [8:0] VBLANK_LINE     = 9'd241;
   localparam logic [8:0] PRERENDER_LINE  = 9'd261;
   localparam logic [8:0] DOT_VERT_STEP   = 9'd256;
   localparam logic [8:0] DOT_HORIZ_COPY  = 9'd257;
   localparam logic [8:0] DOT_VCOPY_FIRST = 9'd280;
   localparam logic [8:0] DOT_VCOPY_LAST  = 9'd304;

   // Scroll address fields.
   localparam logic [14:0] HORIZ_BITS     = 15'h041F;
   localparam logic [14:0] VERT_BITS      = 15'h7BE0;
   localparam logic [14:0] ADDR_HI_KEEP   = 15'h7F00;
   localparam logic [14:0] ADDR_LO_KEEP   = 15'h00FF;
   localparam logic [4:0]  COARSE_Y_WRAP  = 5'd29;
   localparam logic [4:0]  COARSE_Y_MAX   = 5'd31;
   localparam logic [2:0]  FINE_Y_MAX     = 3'd7;
   localparam logic [14:0] ADDR_STEP_ROW  = 15'd32;
   localparam logic [14:0] ADDR_STEP_ONE  = 15'h0001;

   typedef struct packed {
      logic [8:0] dot;
      logic [8:0] line;
      logic [8:0] dot_next;
      logic [8:0] line_next;
      logic       vblank_entry;
      logic       prerender_entry;
   } raster_type;

   typedef struct packed {
      logic [7:0]    bus_rdata;
      vram_code_type vram_access;
      logic [13:0]   vram_addr;
      logic [7:0]    vram_wdata;
      logic          nmi_pulse;
      logic          frame_done;
      logic [14:0]   scroll_addr;
      logic [2:0]    scroll_fine_x;
      logic [8:0]    dot_now;
      logic [8:0]    line_now;
   } rsp_data_type;

endpackage

`default_nettype wire

// ===== src/ppusdt_if.sv =====
// Request and result channel interfaces with valid/ready handshake.
`default_nettype none

interface ppusdt_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [2:0] reg_index;
   logic [7:0] bus_wdata;
   logic       sprite_hit_in;

   modport source (output valid, req_type, reg_index, bus_wdata, sprite_hit_in,
                   input ready);
   modport sink (input valid, req_type, reg_index, bus_wdata, sprite_hit_in,
                 output ready);
endinterface

interface ppusdt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  bus_rdata;
   logic [1:0]  vram_access;
   logic [13:0] vram_addr;
   logic [7:0]  vram_wdata;
   logic        nmi_pulse;
   logic        frame_done;
   logic [14:0] scroll_addr;
   logic [2:0]  scroll_fine_x;
   logic [8:0]  dot_now;
   logic [8:0]  line_now;

   modport source (output valid, bus_rdata, vram_access, vram_addr, vram_wdata,
                   nmi_pulse, frame_done, scroll_addr, scroll_fine_x, dot_now,
                   line_now, input ready);
   modport sink (input valid, bus_rdata, vram_access, vram_addr, vram_wdata,
                 nmi_pulse, frame_done, scroll_addr, scroll_fine_x, dot_now,
                 line_now, output ready);
endinterface

`default_nettype wire

// ===== src/ppu_scroll_register_and_dot_timer.sv =====
// Top level of the picture-unit scroll register file and dot timer.
`default_nettype none
`include "ppu_scroll_register_and_dot_timer_assert.svh"

// The block takes one item per clock while the result register is free: a
// CPU register write, a CPU register read or one dot tick of the picture
// clock. Each accepted item gives exactly one result item, in the cycle after
// it is accepted, from the result register; a new item is accepted in every
// cycle in which the result register is empty or its item is being taken, so
// a steady stream of ticks runs at one item per cycle while results are taken.
// All register updates, scroll address arithmetic and the raster counter step
// for an item happen in the single cycle in which it is accepted. The sprite
// attribute memory is a synchronous memory whose read data are prepared ahead,
// at the address the OAM pointer will hold once the current item is done, so
// an OAM data read needs no wait. Its entries carry valid bits that reset
// clears all together, so there is no clearing pass after reset. The result
// carries the current scroll address, fine X, dot and scanline as they stand
// after the item, plus register read data, the data-port address for register 7
// accesses with the data for writes, and the vblank and NMI indications on
// the tick entering scanline 241. Nothing is accepted while reset is high.
module ppu_scroll_register_and_dot_timer
   import ppusdt_pkg::*;
#(
   parameter int SPRITE_MEM_DEPTH = 256
) (
   input  wire logic     clock,
   input  wire logic     reset,
   ppusdt_req_if.sink    req_chan,
   ppusdt_rsp_if.source  rsp_chan
);

   logic         accept;
   logic         tick;
   raster_type   raster;
   rsp_data_type result;
   rsp_data_type rsp_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   oam_rdata;
   logic         oam_wr_en;
   logic [7:0]   oam_ptr;
   logic [7:0]   oam_rd_ptr;

   // The result register is free when empty or when its item leaves now.
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign tick           = accept && (req_chan.req_type == REQ_TICK);

   ppusdt_raster u_raster (
      .clock  (clock),
      .reset  (reset),
      .tick   (tick),
      .raster (raster)
   );

   ppusdt_regs u_regs (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_type      (req_chan.req_type),
      .reg_index     (req_chan.reg_index),
      .bus_wdata     (req_chan.bus_wdata),
      .sprite_hit_in (req_chan.sprite_hit_in),
      .raster        (raster),
      .oam_rdata     (oam_rdata),
      .oam_wr_en     (oam_wr_en),
      .oam_ptr       (oam_ptr),
      .oam_rd_ptr    (oam_rd_ptr),
      .result        (result)
   );

   ppusdt_oam #(
      .DEPTH (SPRITE_MEM_DEPTH)
   ) u_oam (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (oam_wr_en),
      .wr_ptr  (oam_ptr),
      .wr_data (req_chan.bus_wdata),
      .rd_ptr  (oam_rd_ptr),
      .rd_data (oam_rdata)
   );

   // Result register: loaded on every accepted item, emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.bus_rdata     = rsp_ff.bus_rdata;
   assign rsp_chan.vram_access   = rsp_ff.vram_access;
   assign rsp_chan.vram_addr     = rsp_ff.vram_addr;
   assign rsp_chan.vram_wdata    = rsp_ff.vram_wdata;
   assign rsp_chan.nmi_pulse     = rsp_ff.nmi_pulse;
   assign rsp_chan.frame_done    = rsp_ff.frame_done;
   assign rsp_chan.scroll_addr   = rsp_ff.scroll_addr;
   assign rsp_chan.scroll_fine_x = rsp_ff.scroll_fine_x;
   assign rsp_chan.dot_now       = rsp_ff.dot_now;
   assign rsp_chan.line_now      = rsp_ff.line_now;

   // An NMI is only ever raised together with the start of vblank.
   `PPUSDT_ASSERT_IMP(a_nmi_with_frame, clock, reset, rsp_valid_ff && rsp_ff.nmi_pulse, rsp_ff.frame_done, "nmi pulse without frame done")

   // Vblank start is reported only at the first dot of the vblank line.
   `PPUSDT_ASSERT_IMP(a_frame_position, clock, reset, rsp_valid_ff && rsp_ff.frame_done, (rsp_ff.line_now == VBLANK_LINE) && (rsp_ff.dot_now == 9'd0), "frame done away from vblank start")

   // Every accepted item shows up in the result register on the next cycle.
   `PPUSDT_ASSERT_NEXT(a_accept_to_result, clock, reset, accept, rsp_valid_ff, "accepted item missing from result register")

endmodule

`default_nettype wire

// ===== src/ppusdt_oam.sv =====
// Sprite attribute memory with per-entry valid bits and registered read.
`default_nettype none

module ppusdt_oam
   import ppusdt_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       wr_en,
   input  wire logic [7:0] wr_ptr,
   input  wire logic [7:0] wr_data,
   input  wire logic [7:0] rd_ptr,
   output logic      [7:0] rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [7:0]       mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [7:0]       rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr[AW-1:0]] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_ptr[AW-1:0]];
   end

   // Entries never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_ptr[AW-1:0]] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_ptr[AW-1:0]];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : 8'd0;

endmodule

`default_nettype wire

// ===== src/ppusdt_raster.sv =====
// Dot and scanline counters with vblank and pre-render entry events.
`default_nettype none

module ppusdt_raster
   import ppusdt_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic tick,
   output raster_type raster
);

   logic [8:0] dot_ff;
   logic [8:0] line_ff;
   logic [9:0] dot_inc;
   logic [9:0] line_inc;
   logic       wrap;

   always_comb begin
      dot_inc  = {1'b0, dot_ff} + 10'd1;
      line_inc = {1'b0, line_ff} + 10'd1;
      wrap     = (dot_inc >= DOTS_PER_LINE);

      raster.dot             = dot_ff;
      raster.line            = line_ff;
      raster.dot_next        = wrap ? 9'd0 : dot_inc[8:0];
      raster.line_next       = line_ff;
      raster.vblank_entry    = wrap && (line_inc == {1'b0, VBLANK_LINE});
      raster.prerender_entry = wrap && (line_inc == {1'b0, PRERENDER_LINE});
      if (wrap) begin
         raster.line_next = (line_inc >= LINES_PER_FRAME) ? 9'd0 : line_inc[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff  <= '0;
         line_ff <= '0;
      end else if (tick) begin
         dot_ff  <= raster.dot_next;
         line_ff <= raster.line_next;
      end
   end

endmodule

`default_nettype wire

// ===== src/ppusdt_regs.sv =====
// CPU-visible registers, loopy scroll addresses and per-item result logic.
`default_nettype none

module ppusdt_regs
   import ppusdt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [1:0] req_type,
   input  wire logic [2:0] reg_index,
   input  wire logic [7:0] bus_wdata,
   input  wire logic       sprite_hit_in,
   input  wire raster_type raster,
   input  wire logic [7:0] oam_rdata,
   output logic            oam_wr_en,
   output logic      [7:0] oam_ptr,
   output logic      [7:0] oam_rd_ptr,
   output rsp_data_type    result
);

   logic [7:0]  ctrl_ff,   ctrl_in;
   logic [7:0]  mask_ff,   mask_in;
   logic        vblank_ff, vblank_in;
   logic        hit_ff,    hit_in;
   logic [14:0] temp_ff,   temp_in;
   logic [14:0] cur_ff,    cur_in;
   logic [2:0]  finex_ff,  finex_in;
   logic        toggle_ff, toggle_in;
   logic [7:0]  ptr_ff,    ptr_in;
   logic [14:0] cur_bumped;
   logic [14:0] cur_vstep;
   logic        rendering;
   logic        tick;

   function automatic logic [14:0] step_vertical(input logic [14:0] v);
      logic [14:0] r;
      logic [4:0]  y;
      r = v;
      y = v[9:5];
      if (v[14:12] != FINE_Y_MAX) begin
         r[14:12] = v[14:12] + 3'd1;
      end else begin
         r[14:12] = 3'd0;
         if (y == COARSE_Y_WRAP) begin
            r[9:5] = 5'd0;
            r[11]  = ~v[11];
         end else if (y == COARSE_Y_MAX) begin
            r[9:5] = 5'd0;
         end else begin
            r[9:5] = y + 5'd1;
         end
      end
      return r;
   endfunction

   always_comb begin
      cur_bumped = cur_ff + (ctrl_ff[2] ? ADDR_STEP_ROW : ADDR_STEP_ONE);
      cur_vstep  = step_vertical(cur_ff);
      rendering  = (mask_ff[3] || mask_ff[4]) &&
                   ((raster.line < VISIBLE_LINES) || (raster.line == PRERENDER_LINE));
      tick       = accept && (req_type == REQ_TICK);

      ctrl_in   = ctrl_ff;
      mask_in   = mask_ff;
      vblank_in = vblank_ff;
      hit_in    = hit_ff;
      temp_in   = temp_ff;
      cur_in    = cur_ff;
      finex_in  = finex_ff;
      toggle_in = toggle_ff;
      ptr_in    = ptr_ff;
      oam_wr_en = 1'b0;
      result    = '0;

      if (accept) begin
         unique case (req_type)
            REQ_WRITE: begin
               unique case (reg_index)
                  REG_CTRL: begin
                     ctrl_in        = bus_wdata;
                     temp_in[11:10] = bus_wdata[1:0];
                  end
                  REG_MASK: begin
                     mask_in = bus_wdata;
                  end
                  REG_OAM_ADDR: begin
                     ptr_in = bus_wdata;
                  end
                  REG_OAM_DATA: begin
                     oam_wr_en = 1'b1;
                     ptr_in    = ptr_ff + 8'd1;
                  end
                  REG_SCROLL: begin
                     if (toggle_ff) begin
                        temp_in[14:12] = bus_wdata[2:0];
                        temp_in[9:5]   = bus_wdata[7:3];
                     end else begin
                        finex_in     = bus_wdata[2:0];
                        temp_in[4:0] = bus_wdata[7:3];
                     end
                     toggle_in = ~toggle_ff;
                  end
                  REG_ADDR: begin
                     if (toggle_ff) begin
                        temp_in = (temp_ff & ADDR_HI_KEEP) | {7'd0, bus_wdata};
                        cur_in  = temp_in;
                     end else begin
                        temp_in = (temp_ff & ADDR_LO_KEEP) | {1'b0, bus_wdata[5:0], 8'd0};
                     end
                     toggle_in = ~toggle_ff;
                  end
                  REG_DATA: begin
                     result.vram_access = VRAM_WRITE;
                     result.vram_addr   = cur_ff[13:0];
                     result.vram_wdata  = bus_wdata;
                     cur_in             = cur_bumped;
                  end
                  default: begin
                  end
               endcase
            end
            REQ_READ: begin
               unique case (reg_index)
                  REG_STATUS: begin
                     result.bus_rdata = {vblank_ff, hit_ff, 6'd0};
                     vblank_in        = 1'b0;
                     toggle_in        = 1'b0;
                  end
                  REG_OAM_DATA: begin
                     result.bus_rdata = oam_rdata;
                  end
                  REG_DATA: begin
                     result.vram_access = VRAM_READ;
                     result.vram_addr   = cur_ff[13:0];
                     cur_in             = cur_bumped;
                  end
                  default: begin
                  end
               endcase
            end
            REQ_TICK: begin
               if (sprite_hit_in) begin
                  hit_in = 1'b1;
               end
               if (rendering) begin
                  if (raster.dot == DOT_VERT_STEP) begin
                     cur_in = cur_vstep;
                  end else if (raster.dot == DOT_HORIZ_COPY) begin
                     cur_in = (cur_ff & ~HORIZ_BITS) | (temp_ff & HORIZ_BITS);
                  end else if ((raster.line == PRERENDER_LINE) &&
                               (raster.dot >= DOT_VCOPY_FIRST) &&
                               (raster.dot <= DOT_VCOPY_LAST)) begin
                     cur_in = (cur_ff & ~VERT_BITS) | (temp_ff & VERT_BITS);
                  end
               end
               if (raster.vblank_entry) begin
                  vblank_in         = 1'b1;
                  result.frame_done = 1'b1;
                  result.nmi_pulse  = ctrl_ff[7];
               end else if (raster.prerender_entry) begin
                  vblank_in = 1'b0;
                  hit_in    = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      result.scroll_addr   = cur_in;
      result.scroll_fine_x = finex_in;
      result.dot_now       = tick ? raster.dot_next : raster.dot;
      result.line_now      = tick ? raster.line_next : raster.line;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff   <= '0;
         mask_ff   <= '0;
         vblank_ff <= 1'b0;
         hit_ff    <= 1'b0;
         temp_ff   <= '0;
         cur_ff    <= '0;
         finex_ff  <= '0;
         toggle_ff <= 1'b0;
         ptr_ff    <= '0;
      end else begin
         ctrl_ff   <= ctrl_in;
         mask_ff   <= mask_in;
         vblank_ff <= vblank_in;
         hit_ff    <= hit_in;
         temp_ff   <= temp_in;
         cur_ff    <= cur_in;
         finex_ff  <= finex_in;
         toggle_ff <= toggle_in;
         ptr_ff    <= ptr_in;
      end
   end

   assign oam_ptr    = ptr_ff;
   assign oam_rd_ptr = ptr_in;

endmodule

`default_nettype wire
